### hdl/rsj_pkg.sv
// ============================================================================
// rsj_pkg
// Shared widths, types, row tables and constants for the rod strain
// Jacobian and force term pipeline.
// ============================================================================
package rsj_pkg;

    // Vector sizes.
    localparam int N_AXES  = 6;
    localparam int N_SLOTS = 4;
    localparam int ROW_W   = 3;
    localparam int IDX_W   = 3;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd5;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_STIFF_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_STIFF_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_STIFF_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_STIFF_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_STIFF_4 = 3'd4;
    localparam logic [IDX_W-1:0] REG_STIFF_5 = 3'd5;

    // Datapath widths.
    localparam int STRAIN_W = 32;  // signed Q4.28
    localparam int STIFF_W  = 32;  // unsigned Q24.8
    localparam int DIFF_W   = 33;  // strain minus rest strain
    localparam int FK_W     = 64;  // f*k, Q.36
    localparam int KD_W     = 65;  // k*d, Q.36
    localparam int JT_W     = 66;  // signed sum of f*k and k*d
    localparam int PART_W   = 65;  // half products of f*k*d
    localparam int TERM_W   = 97;  // f*k*d, Q.64
    localparam int PAIR_W   = 98;  // sum of two terms
    localparam int RSUM_W   = 99;  // full force sum with rounding offset
    localparam int OUT_W    = 64;  // signed Q27.36
    localparam int RND_SH   = 28;
    localparam int HALF_W   = 32;

    localparam logic [RSUM_W-1:0] RND_HALF = RSUM_W'(1) << (RND_SH - 1);
    localparam logic [OUT_W-1:0]  SAT_POS  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]  SAT_NEG  = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic signed [STRAIN_W-1:0] t_strain;
    typedef logic        [STIFF_W-1:0]  t_stiff;
    typedef logic signed [DIFF_W-1:0]   t_diff;

    // One product slot of a row: f index a, stiffness index b for f*k and
    // f*k*d, index c for k*d, enables, signs and the Jacobian column.
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             fk_en;
        logic             kd_en;
        logic             fk_neg;
        logic             kd_neg;
        logic [IDX_W-1:0] col;
    } t_slot_desc;

    typedef t_slot_desc [N_SLOTS-1:0] t_row_desc;

    // Operands of one slot as they leave the row sequencer.
    typedef struct packed {
        t_strain f;
        t_stiff  kb;
        t_stiff  kc;
        t_diff   dc;
        t_diff   db;
        logic    fk_neg;
        logic    kd_neg;
    } t_slot_op;

    // Load enables of the six pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } t_pipe_en;

    function automatic t_slot_desc mk_slot(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b,
        input logic [IDX_W-1:0] c,
        input logic             fk_en,
        input logic             kd_en,
        input logic             fk_neg,
        input logic             kd_neg,
        input logic [IDX_W-1:0] col
    );
        t_slot_desc d;
        d.a      = a;
        d.b      = b;
        d.c      = c;
        d.fk_en  = fk_en;
        d.kd_en  = kd_en;
        d.fk_neg = fk_neg;
        d.kd_neg = kd_neg;
        d.col    = col;
        return d;
    endfunction

    // Product layout of each Jacobian row. Rows 0 to 2 hold two pure f*k
    // entries and two pure k*d entries; rows 3 to 5 hold four mixed entries.
    // The force term of a row is the signed sum of f*k*d over its f*k slots.
    function automatic t_row_desc row_desc(input logic [ROW_W-1:0] row);
        t_row_desc d;
        d = '0;
        unique case (row)
            3'd0: begin
                d[0] = mk_slot(3'd5, 3'd1, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd1);
                d[1] = mk_slot(3'd4, 3'd2, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 3'd2);
                d[2] = mk_slot(3'd0, 3'd0, 3'd2, 1'b0, 1'b1, 1'b0, 1'b1, 3'd4);
                d[3] = mk_slot(3'd0, 3'd0, 3'd1, 1'b0, 1'b1, 1'b0, 1'b0, 3'd5);
            end
            3'd1: begin
                d[0] = mk_slot(3'd5, 3'd0, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0);
                d[1] = mk_slot(3'd3, 3'd2, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd2);
                d[2] = mk_slot(3'd0, 3'd0, 3'd2, 1'b0, 1'b1, 1'b0, 1'b0, 3'd3);
                d[3] = mk_slot(3'd0, 3'd0, 3'd0, 1'b0, 1'b1, 1'b0, 1'b1, 3'd5);
            end
            3'd2: begin
                d[0] = mk_slot(3'd4, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0);
                d[1] = mk_slot(3'd3, 3'd1, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 3'd1);
                d[2] = mk_slot(3'd0, 3'd0, 3'd1, 1'b0, 1'b1, 1'b0, 1'b1, 3'd3);
                d[3] = mk_slot(3'd0, 3'd0, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 3'd4);
            end
            3'd3: begin
                d[0] = mk_slot(3'd2, 3'd1, 3'd2, 1'b1, 1'b1, 1'b0, 1'b1, 3'd1);
                d[1] = mk_slot(3'd1, 3'd2, 3'd1, 1'b1, 1'b1, 1'b1, 1'b0, 3'd2);
                d[2] = mk_slot(3'd5, 3'd4, 3'd5, 1'b1, 1'b1, 1'b0, 1'b1, 3'd4);
                d[3] = mk_slot(3'd4, 3'd5, 3'd4, 1'b1, 1'b1, 1'b1, 1'b0, 3'd5);
            end
            3'd4: begin
                d[0] = mk_slot(3'd2, 3'd0, 3'd2, 1'b1, 1'b1, 1'b1, 1'b0, 3'd0);
                d[1] = mk_slot(3'd0, 3'd2, 3'd0, 1'b1, 1'b1, 1'b0, 1'b1, 3'd2);
                d[2] = mk_slot(3'd5, 3'd3, 3'd5, 1'b1, 1'b1, 1'b1, 1'b0, 3'd3);
                d[3] = mk_slot(3'd3, 3'd5, 3'd3, 1'b1, 1'b1, 1'b0, 1'b1, 3'd5);
            end
            3'd5: begin
                d[0] = mk_slot(3'd1, 3'd0, 3'd1, 1'b1, 1'b1, 1'b0, 1'b1, 3'd0);
                d[1] = mk_slot(3'd0, 3'd1, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 3'd1);
                d[2] = mk_slot(3'd4, 3'd3, 3'd4, 1'b1, 1'b1, 1'b0, 1'b1, 3'd3);
                d[3] = mk_slot(3'd3, 3'd4, 3'd3, 1'b1, 1'b1, 1'b1, 1'b0, 3'd4);
            end
            default: begin
                d = '0;
            end
        endcase
        return d;
    endfunction

endpackage

### hdl/rsj_row_seq.sv
// ============================================================================
// rsj_row_seq
// Captures one strain request, then issues its six rows one per cycle while
// stage 1 can load; it registers the selected operands of the four slots.
// ============================================================================
module rsj_row_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rsj_pkg::t_strain              i_strain      [rsj_pkg::N_AXES],
    input  rsj_pkg::t_strain              i_rest_strain [rsj_pkg::N_AXES],
    input  rsj_pkg::t_stiff               i_stiff       [rsj_pkg::N_AXES],
    input  rsj_pkg::t_pipe_en             i_pipe_en,
    output logic                          o_busy,
    output logic [rsj_pkg::ROW_W-1:0]     o_row,
    output rsj_pkg::t_slot_op             o_op          [rsj_pkg::N_SLOTS]
);

    logic                          r_busy;
    logic [rsj_pkg::ROW_W-1:0]     r_row;
    logic [rsj_pkg::ROW_W-1:0]     n_row;
    logic                          n_busy;
    rsj_pkg::t_strain              r_f [rsj_pkg::N_AXES];
    rsj_pkg::t_diff                r_d [rsj_pkg::N_AXES];
    rsj_pkg::t_diff                n_d [rsj_pkg::N_AXES];
    rsj_pkg::t_slot_op             r_op [rsj_pkg::N_SLOTS];
    rsj_pkg::t_slot_op             n_op [rsj_pkg::N_SLOTS];
    logic [rsj_pkg::ROW_W-1:0]     r_s1_row;
    rsj_pkg::t_row_desc            w_desc;
    logic                          w_issue;
    logic                          w_accept;

    // A row moves into stage 1 whenever one is pending and stage 1 can load.
    assign w_issue  = r_busy & i_pipe_en.ld1;
    assign o_ready  = ~r_busy | (w_issue & (r_row == rsj_pkg::ROW_LAST));
    assign w_accept = i_valid & o_ready;
    assign o_busy   = r_busy;
    assign o_row    = r_s1_row;
    assign o_op     = r_op;

    // Strain differences are formed as the request is captured.
    always_comb begin
        for (int i = 0; i < rsj_pkg::N_AXES; i++) begin
            n_d[i] = i_strain[i] - i_rest_strain[i];
        end
    end

    // Row counter.
    always_comb begin
        n_busy = r_busy;
        n_row  = r_row;
        if (w_accept) begin
            n_busy = 1'b1;
            n_row  = '0;
        end else if (w_issue) begin
            if (r_row == rsj_pkg::ROW_LAST) begin
                n_busy = 1'b0;
            end else begin
                n_row = r_row + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else begin
            r_busy <= n_busy;
            r_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f <= i_strain;
            r_d <= n_d;
        end
    end

    // Operand selection for the current row, as an AND-OR over the axes.
    // A slot without f*k gets f = 0, a slot without k*d gets k = 0.
    always_comb begin
        w_desc = rsj_pkg::row_desc(r_row);
        for (int s = 0; s < rsj_pkg::N_SLOTS; s++) begin
            n_op[s]        = '0;
            n_op[s].fk_neg = w_desc[s].fk_neg;
            n_op[s].kd_neg = w_desc[s].kd_neg;
            for (int i = 0; i < rsj_pkg::N_AXES; i++) begin
                if (w_desc[s].fk_en && (w_desc[s].a == rsj_pkg::IDX_W'(i))) begin
                    n_op[s].f = r_f[i];
                end
                if (w_desc[s].b == rsj_pkg::IDX_W'(i)) begin
                    n_op[s].kb = i_stiff[i];
                    n_op[s].db = r_d[i];
                end
                if (w_desc[s].c == rsj_pkg::IDX_W'(i)) begin
                    n_op[s].dc = r_d[i];
                    if (w_desc[s].kd_en) begin
                        n_op[s].kc = i_stiff[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld1) begin
            r_op     <= n_op;
            r_s1_row <= r_row;
        end
    end

endmodule

### hdl/rsj_slot_lane.sv
// ============================================================================
// rsj_slot_lane
// Arithmetic of one product slot: f*k and k*d, their signed Jacobian sum
// with saturation, and the exact f*k*d force term built from two halves.
// ============================================================================
module rsj_slot_lane (
    input  logic                                   i_clk,
    input  rsj_pkg::t_pipe_en                      i_pipe_en,
    input  rsj_pkg::t_slot_op                      i_op,
    output logic signed [rsj_pkg::OUT_W-1:0]       o_j,
    output logic                                   o_jsat,
    output logic signed [rsj_pkg::TERM_W-1:0]      o_term
);

    // Stage 2 products.
    logic signed [rsj_pkg::STRAIN_W-1:0]  w_f;
    logic signed [rsj_pkg::STIFF_W:0]     w_kb;
    logic signed [rsj_pkg::STIFF_W:0]     w_kc;
    logic signed [rsj_pkg::DIFF_W-1:0]    w_dc;
    logic signed [rsj_pkg::FK_W:0]        n_fk_full;
    logic signed [rsj_pkg::KD_W:0]        n_kd_full;
    logic signed [rsj_pkg::FK_W-1:0]      r_fk;
    logic signed [rsj_pkg::KD_W-1:0]      r_kd;
    logic signed [rsj_pkg::DIFF_W-1:0]    r_db2;
    logic                                 r_fk_neg2;
    logic                                 r_kd_neg2;

    // Stage 3 half products and Jacobian sum.
    logic signed [rsj_pkg::HALF_W:0]      w_fk_lo;
    logic signed [rsj_pkg::HALF_W-1:0]    w_fk_hi;
    logic signed [rsj_pkg::PART_W:0]      n_plo_full;
    logic signed [rsj_pkg::PART_W-1:0]    n_phi;
    logic signed [rsj_pkg::JT_W-1:0]      w_fk_x;
    logic signed [rsj_pkg::JT_W-1:0]      w_kd_x;
    logic signed [rsj_pkg::JT_W-1:0]      n_jt;
    logic signed [rsj_pkg::PART_W-1:0]    r_plo;
    logic signed [rsj_pkg::PART_W-1:0]    r_phi;
    logic signed [rsj_pkg::JT_W-1:0]      r_jt;
    logic                                 r_fk_neg3;

    // Stage 4 force term and saturated Jacobian entry.
    logic signed [rsj_pkg::TERM_W-1:0]    w_plo_x;
    logic signed [rsj_pkg::TERM_W-1:0]    w_phi_x;
    logic signed [rsj_pkg::TERM_W-1:0]    w_mag;
    logic signed [rsj_pkg::TERM_W-1:0]    n_term;
    logic signed [rsj_pkg::OUT_W-1:0]     n_j;
    logic                                 n_jsat;
    logic                                 w_fits;
    logic signed [rsj_pkg::TERM_W-1:0]    r_term;
    logic signed [rsj_pkg::OUT_W-1:0]     r_j;
    logic                                 r_jsat;

    // Stage 2: f*k is at most 63 bits of magnitude, k*d at most 64.
    assign w_f       = i_op.f;
    assign w_kb      = $signed({1'b0, i_op.kb});
    assign w_kc      = $signed({1'b0, i_op.kc});
    assign w_dc      = i_op.dc;
    assign n_fk_full = w_f * w_kb;
    assign n_kd_full = w_kc * w_dc;

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld2) begin
            r_fk      <= n_fk_full[rsj_pkg::FK_W-1:0];
            r_kd      <= n_kd_full[rsj_pkg::KD_W-1:0];
            r_db2     <= i_op.db;
            r_fk_neg2 <= i_op.fk_neg;
            r_kd_neg2 <= i_op.kd_neg;
        end
    end

    // Stage 3: f*k*d split into low-half and high-half products of f*k.
    assign w_fk_lo    = $signed({1'b0, r_fk[rsj_pkg::HALF_W-1:0]});
    assign w_fk_hi    = r_fk[rsj_pkg::FK_W-1:rsj_pkg::HALF_W];
    assign n_plo_full = w_fk_lo * r_db2;
    assign n_phi      = w_fk_hi * r_db2;
    assign w_fk_x     = r_fk;
    assign w_kd_x     = r_kd;
    assign n_jt       = (r_fk_neg2 ? -w_fk_x : w_fk_x) + (r_kd_neg2 ? -w_kd_x : w_kd_x);

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld3) begin
            r_plo     <= n_plo_full[rsj_pkg::PART_W-1:0];
            r_phi     <= n_phi;
            r_jt      <= n_jt;
            r_fk_neg3 <= r_fk_neg2;
        end
    end

    // Stage 4: recombine the halves with the slot sign; clamp the entry.
    assign w_plo_x = r_plo;
    assign w_phi_x = r_phi;
    assign w_mag   = w_plo_x + (w_phi_x <<< rsj_pkg::HALF_W);
    assign n_term  = r_fk_neg3 ? -w_mag : w_mag;
    assign w_fits  = (&r_jt[rsj_pkg::JT_W-1:rsj_pkg::OUT_W-1]) |
                     ~(|r_jt[rsj_pkg::JT_W-1:rsj_pkg::OUT_W-1]);

    always_comb begin
        n_jsat = ~w_fits;
        if (w_fits) begin
            n_j = r_jt[rsj_pkg::OUT_W-1:0];
        end else if (r_jt[rsj_pkg::JT_W-1]) begin
            n_j = rsj_pkg::SAT_NEG;
        end else begin
            n_j = rsj_pkg::SAT_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld4) begin
            r_term <= n_term;
            r_j    <= n_j;
            r_jsat <= n_jsat;
        end
    end

    assign o_j    = r_j;
    assign o_jsat = r_jsat;
    assign o_term = r_term;

endmodule

### hdl/rsj_row_reduce.sv
// ============================================================================
// rsj_row_reduce
// Places the four slot values of a row into their Jacobian columns, sums
// the force terms, rounds to Q27.36 with saturation and holds the result.
// ============================================================================
module rsj_row_reduce (
    input  logic                               i_clk,
    input  rsj_pkg::t_pipe_en                  i_pipe_en,
    input  logic [rsj_pkg::ROW_W-1:0]          i_row,
    input  logic signed [rsj_pkg::OUT_W-1:0]   i_j      [rsj_pkg::N_SLOTS],
    input  logic                               i_jsat   [rsj_pkg::N_SLOTS],
    input  logic signed [rsj_pkg::TERM_W-1:0]  i_term   [rsj_pkg::N_SLOTS],
    output logic [rsj_pkg::ROW_W-1:0]          o_row_index,
    output logic [rsj_pkg::OUT_W-1:0]          o_entry  [rsj_pkg::N_AXES],
    output logic [rsj_pkg::OUT_W-1:0]          o_force_term,
    output logic                               o_saturated,
    output logic                               o_last_row
);

    logic [rsj_pkg::ROW_W-1:0]          r_row2;
    logic [rsj_pkg::ROW_W-1:0]          r_row3;
    logic [rsj_pkg::ROW_W-1:0]          r_row4;
    logic [rsj_pkg::ROW_W-1:0]          r_row5;
    logic [rsj_pkg::ROW_W-1:0]          r_row6;

    rsj_pkg::t_row_desc                 w_desc;
    logic [rsj_pkg::OUT_W-1:0]          n_ent [rsj_pkg::N_AXES];
    logic                               n_jsat;
    logic signed [rsj_pkg::PAIR_W-1:0]  w_t_x [rsj_pkg::N_SLOTS];
    logic signed [rsj_pkg::PAIR_W-1:0]  n_p0;
    logic signed [rsj_pkg::PAIR_W-1:0]  n_p1;
    logic [rsj_pkg::OUT_W-1:0]          r_ent5 [rsj_pkg::N_AXES];
    logic                               r_jsat5;
    logic signed [rsj_pkg::PAIR_W-1:0]  r_p0;
    logic signed [rsj_pkg::PAIR_W-1:0]  r_p1;

    logic signed [rsj_pkg::RSUM_W-1:0]  w_p0_x;
    logic signed [rsj_pkg::RSUM_W-1:0]  w_p1_x;
    logic signed [rsj_pkg::RSUM_W-1:0]  w_rsum;
    logic                               w_rfits;
    logic [rsj_pkg::OUT_W-1:0]          n_force;
    logic [rsj_pkg::OUT_W-1:0]          r_ent6 [rsj_pkg::N_AXES];
    logic [rsj_pkg::OUT_W-1:0]          r_force;
    logic                               r_sat6;

    // Row index travels alongside the slot lanes.
    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld2) begin
            r_row2 <= i_row;
        end
        if (i_pipe_en.ld3) begin
            r_row3 <= r_row2;
        end
        if (i_pipe_en.ld4) begin
            r_row4 <= r_row3;
        end
        if (i_pipe_en.ld5) begin
            r_row5 <= r_row4;
        end
        if (i_pipe_en.ld6) begin
            r_row6 <= r_row5;
        end
    end

    // Stage 5: column placement (unused columns are structural zeros) and
    // pairwise force sums.
    always_comb begin
        w_desc = rsj_pkg::row_desc(r_row4);
        for (int c = 0; c < rsj_pkg::N_AXES; c++) begin
            n_ent[c] = '0;
            for (int s = 0; s < rsj_pkg::N_SLOTS; s++) begin
                if (w_desc[s].col == rsj_pkg::IDX_W'(c)) begin
                    n_ent[c] = i_j[s];
                end
            end
        end
        n_jsat = 1'b0;
        for (int s = 0; s < rsj_pkg::N_SLOTS; s++) begin
            n_jsat  = n_jsat | i_jsat[s];
            w_t_x[s] = i_term[s];
        end
        n_p0 = w_t_x[0] + w_t_x[1];
        n_p1 = w_t_x[2] + w_t_x[3];
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld5) begin
            r_ent5  <= n_ent;
            r_jsat5 <= n_jsat;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
        end
    end

    // Stage 6: final sum, round half up by 28 bits, clamp to 64 bits.
    assign w_p0_x  = r_p0;
    assign w_p1_x  = r_p1;
    assign w_rsum  = w_p0_x + w_p1_x + rsj_pkg::RND_HALF;
    assign w_rfits =
        (&w_rsum[rsj_pkg::RSUM_W-1:rsj_pkg::RND_SH+rsj_pkg::OUT_W-1]) |
        ~(|w_rsum[rsj_pkg::RSUM_W-1:rsj_pkg::RND_SH+rsj_pkg::OUT_W-1]);

    always_comb begin
        if (w_rfits) begin
            n_force = w_rsum[rsj_pkg::RND_SH+rsj_pkg::OUT_W-1:rsj_pkg::RND_SH];
        end else if (w_rsum[rsj_pkg::RSUM_W-1]) begin
            n_force = rsj_pkg::SAT_NEG;
        end else begin
            n_force = rsj_pkg::SAT_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe_en.ld6) begin
            r_ent6  <= r_ent5;
            r_force <= n_force;
            r_sat6  <= r_jsat5 | ~w_rfits;
        end
    end

    assign o_row_index  = r_row6;
    assign o_entry      = r_ent6;
    assign o_force_term = r_force;
    assign o_saturated  = r_sat6;
    assign o_last_row   = (r_row6 == rsj_pkg::ROW_LAST);

endmodule

### hdl/rod_strain_jacobian_and_term_unit.sv
// ============================================================================
// rod_strain_jacobian_and_term_unit
// Rod strain Jacobian rows and initial force term, six-stage row pipeline.
// ============================================================================
// Usage:
//   Configuration: write stiffness_0..5 (unsigned Q24.8) through i_cfg_valid,
//   i_cfg_index and i_cfg_data while the unit is idle; o_cfg_ready is always
//   high and writes to indexes 6 and 7 are dropped.
//   Input: one request carries strain and rest strain 6-vectors (signed
//   Q4.28) and is taken on i_valid & o_ready.
//   Output: each request yields six results, rows 0 to 5 in order, each with
//   six Jacobian entries, one force component (signed Q27.36), a saturation
//   flag and last_row on row 5. Results move on o_valid & i_ready.
//   Sequencing: the row sequencer feeds one row per cycle, while stage 1 can
//   load, into the shared four-slot multiplier lanes. The next request is
//   taken in the cycle that row 5 of the current one is issued.
//   Stalls: when i_ready is low, the output stage holds its row, rows behind
//   it fill the bubbles ahead, and nothing is dropped or repeated.
//   Reset: synchronous, active low; clears the pipeline valid bits, the
//   sequencer and the stiffness registers to zero.
// ============================================================================
module rod_strain_jacobian_and_term_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsj_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [rsj_pkg::STIFF_W-1:0]   i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_strain_0,
    input  logic signed [31:0]            i_strain_1,
    input  logic signed [31:0]            i_strain_2,
    input  logic signed [31:0]            i_strain_3,
    input  logic signed [31:0]            i_strain_4,
    input  logic signed [31:0]            i_strain_5,
    input  logic signed [31:0]            i_rest_strain_0,
    input  logic signed [31:0]            i_rest_strain_1,
    input  logic signed [31:0]            i_rest_strain_2,
    input  logic signed [31:0]            i_rest_strain_3,
    input  logic signed [31:0]            i_rest_strain_4,
    input  logic signed [31:0]            i_rest_strain_5,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_row_index,
    output logic signed [63:0]            o_entry_0,
    output logic signed [63:0]            o_entry_1,
    output logic signed [63:0]            o_entry_2,
    output logic signed [63:0]            o_entry_3,
    output logic signed [63:0]            o_entry_4,
    output logic signed [63:0]            o_entry_5,
    output logic signed [63:0]            o_force_term,
    output logic                          o_saturated,
    output logic                          o_last_row
);

    rsj_pkg::t_stiff                      r_stiff [rsj_pkg::N_AXES];
    rsj_pkg::t_stiff                      n_stiff [rsj_pkg::N_AXES];
    rsj_pkg::t_strain                     w_strain [rsj_pkg::N_AXES];
    rsj_pkg::t_strain                     w_rest [rsj_pkg::N_AXES];
    rsj_pkg::t_pipe_en                    w_pipe_en;
    logic [5:0]                           r_vld;
    logic [5:0]                           n_vld;
    logic                                 w_busy;
    logic [rsj_pkg::ROW_W-1:0]            w_s1_row;
    rsj_pkg::t_slot_op                    w_op [rsj_pkg::N_SLOTS];
    logic signed [rsj_pkg::OUT_W-1:0]     w_j [rsj_pkg::N_SLOTS];
    logic                                 w_jsat [rsj_pkg::N_SLOTS];
    logic signed [rsj_pkg::TERM_W-1:0]    w_term [rsj_pkg::N_SLOTS];
    logic [rsj_pkg::OUT_W-1:0]            w_entry [rsj_pkg::N_AXES];
    logic [rsj_pkg::OUT_W-1:0]            w_force;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_stiff = r_stiff;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsj_pkg::REG_STIFF_0: n_stiff[0] = i_cfg_data;
                rsj_pkg::REG_STIFF_1: n_stiff[1] = i_cfg_data;
                rsj_pkg::REG_STIFF_2: n_stiff[2] = i_cfg_data;
                rsj_pkg::REG_STIFF_3: n_stiff[3] = i_cfg_data;
                rsj_pkg::REG_STIFF_4: n_stiff[4] = i_cfg_data;
                rsj_pkg::REG_STIFF_5: n_stiff[5] = i_cfg_data;
                default: begin
                    n_stiff = r_stiff;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rsj_pkg::N_AXES; i++) begin
                r_stiff[i] <= '0;
            end
        end else begin
            r_stiff <= n_stiff;
        end
    end

    // Request fields gathered into vectors.
    assign w_strain[0] = i_strain_0;
    assign w_strain[1] = i_strain_1;
    assign w_strain[2] = i_strain_2;
    assign w_strain[3] = i_strain_3;
    assign w_strain[4] = i_strain_4;
    assign w_strain[5] = i_strain_5;
    assign w_rest[0]   = i_rest_strain_0;
    assign w_rest[1]   = i_rest_strain_1;
    assign w_rest[2]   = i_rest_strain_2;
    assign w_rest[3]   = i_rest_strain_3;
    assign w_rest[4]   = i_rest_strain_4;
    assign w_rest[5]   = i_rest_strain_5;

    // Stage load enables: a stage loads when it is empty or its row moves on.
    assign w_pipe_en.ld6 = ~r_vld[5] | i_ready;
    assign w_pipe_en.ld5 = ~r_vld[4] | w_pipe_en.ld6;
    assign w_pipe_en.ld4 = ~r_vld[3] | w_pipe_en.ld5;
    assign w_pipe_en.ld3 = ~r_vld[2] | w_pipe_en.ld4;
    assign w_pipe_en.ld2 = ~r_vld[1] | w_pipe_en.ld3;
    assign w_pipe_en.ld1 = ~r_vld[0] | w_pipe_en.ld2;

    // Valid bits follow the rows through the stages.
    always_comb begin
        n_vld    = r_vld;
        n_vld[0] = w_pipe_en.ld1 ? w_busy   : r_vld[0];
        n_vld[1] = w_pipe_en.ld2 ? r_vld[0] : r_vld[1];
        n_vld[2] = w_pipe_en.ld3 ? r_vld[1] : r_vld[2];
        n_vld[3] = w_pipe_en.ld4 ? r_vld[2] : r_vld[3];
        n_vld[4] = w_pipe_en.ld5 ? r_vld[3] : r_vld[4];
        n_vld[5] = w_pipe_en.ld6 ? r_vld[4] : r_vld[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[5];

    // Row sequencer and operand select.
    rsj_row_seq u_row_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_strain      (w_strain),
        .i_rest_strain (w_rest),
        .i_stiff       (r_stiff),
        .i_pipe_en     (w_pipe_en),
        .o_busy        (w_busy),
        .o_row         (w_s1_row),
        .o_op          (w_op)
    );

    // Four product lanes, one per slot of a row.
    for (genvar s = 0; s < rsj_pkg::N_SLOTS; s++) begin : g_lane
        rsj_slot_lane u_lane (
            .i_clk     (i_clk),
            .i_pipe_en (w_pipe_en),
            .i_op      (w_op[s]),
            .o_j       (w_j[s]),
            .o_jsat    (w_jsat[s]),
            .o_term    (w_term[s])
        );
    end

    // Column placement, force rounding and output register.
    rsj_row_reduce u_row_reduce (
        .i_clk        (i_clk),
        .i_pipe_en    (w_pipe_en),
        .i_row        (w_s1_row),
        .i_j          (w_j),
        .i_jsat       (w_jsat),
        .i_term       (w_term),
        .o_row_index  (o_row_index),
        .o_entry      (w_entry),
        .o_force_term (w_force),
        .o_saturated  (o_saturated),
        .o_last_row   (o_last_row)
    );

    assign o_entry_0    = w_entry[0];
    assign o_entry_1    = w_entry[1];
    assign o_entry_2    = w_entry[2];
    assign o_entry_3    = w_entry[3];
    assign o_entry_4    = w_entry[4];
    assign o_entry_5    = w_entry[5];
    assign o_force_term = w_force;

endmodule
